// ----- hw/rtl/kfc_pkg.sv -----
package kfc_pkg;

    localparam int KMER_LENGTH = 16;
    localparam int TABLE_BITS  = 16;
    localparam int COUNT_BITS  = 32;

    localparam int CODE_W      = 2 * KMER_LENGTH;
    localparam int FILL_W      = $clog2(KMER_LENGTH + 1);
    localparam int TABLE_DEPTH = 2 ** TABLE_BITS;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam logic [1:0] MODE_FEED  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  data_byte;
        logic [15:0] read_index;
    } in_word_t;

    typedef struct packed {
        logic [31:0] count;
        logic [15:0] count_index;
    } out_word_t;

    typedef struct packed {
        logic       shift;
        logic       use_input;
        logic [1:0] base_sel;
        logic       load_byte;
        logic       issue_read;
        logic       clr_window;
        logic       clr_start;
        logic       clr_write;
    } ctrl_cmd_t;

    typedef struct packed {
        logic read_ok;
        logic clr_last;
    } dp_status_t;

endpackage

// ----- hw/rtl/kfc_ctrl.sv -----
module kfc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_mode,
    input  kfc_pkg::dp_status_t   stat,
    output kfc_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FEED
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] base_cnt_reg, base_cnt_next;
    logic       accept;

    assign s_ready = (state_reg == ST_IDLE)
                     && ((s_mode != kfc_pkg::MODE_READ) || stat.read_ok);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next    = state_reg;
        base_cnt_next = base_cnt_reg;
        cmd           = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_mode)
                        kfc_pkg::MODE_FEED: begin
                            cmd.shift     = 1'b1;
                            cmd.use_input = 1'b1;
                            cmd.base_sel  = 2'd0;
                            cmd.load_byte = 1'b1;
                            base_cnt_next = 2'd1;
                            state_next    = ST_FEED;
                        end
                        kfc_pkg::MODE_READ: begin
                            cmd.issue_read = 1'b1;
                        end
                        kfc_pkg::MODE_CLEAR: begin
                            cmd.clr_window = 1'b1;
                            cmd.clr_start  = 1'b1;
                            state_next     = ST_CLEAR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FEED: begin
                cmd.shift     = 1'b1;
                cmd.base_sel  = base_cnt_reg;
                base_cnt_next = base_cnt_reg + 2'd1;
                if (base_cnt_reg == 2'd3) begin
                    state_next = ST_IDLE;
                end
            end
            ST_CLEAR: begin
                cmd.clr_write = 1'b1;
                if (stat.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            base_cnt_reg <= 2'd0;
        end else begin
            state_reg    <= state_next;
            base_cnt_reg <= base_cnt_next;
        end
    end

endmodule

// ----- hw/rtl/kfc_datapath.sv -----
module kfc_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  kfc_pkg::in_word_t    s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output kfc_pkg::out_word_t   m_data,
    input  logic                 cfg_valid,
    input  logic [15:0]          cfg_data,
    input  kfc_pkg::ctrl_cmd_t   cmd,
    output kfc_pkg::dp_status_t  stat
);

    localparam int TB = kfc_pkg::TABLE_BITS;
    localparam int CW = kfc_pkg::CODE_W;
    localparam int NB = kfc_pkg::COUNT_BITS;
    localparam int FW = kfc_pkg::FILL_W;

    logic [NB-1:0] mem [kfc_pkg::TABLE_DEPTH];

    logic [CW-1:0] window_reg, window_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [15:0]   pass_sel_reg;
    logic [7:0]    byte_reg;
    logic [TB-1:0] clr_addr_reg;

    logic [NB-1:0] mem_q_reg;
    logic          s2_cnt_reg;
    logic          s2_rd_reg;
    logic [TB-1:0] s2_addr_reg;

    logic          wr_valid_reg;
    logic [TB-1:0] wr_addr_reg;
    logic [NB-1:0] wr_data_reg;

    logic                m_valid_reg;
    kfc_pkg::out_word_t  m_data_reg;

    logic [7:0]    byte_sel;
    logic [1:0]    base;
    logic          hit;
    logic [TB-1:0] rd_addr;
    logic [NB-1:0] s2_val;
    logic [NB-1:0] s2_inc;

    assign byte_sel    = cmd.use_input ? s_data.data_byte : byte_reg;
    assign base        = 2'(byte_sel >> (3'd6 - {cmd.base_sel, 1'b0}));
    assign window_next = {window_reg[CW-3:0], base};
    assign fill_next   = (fill_reg < FW'(kfc_pkg::KMER_LENGTH)) ? fill_reg + 1'b1 : fill_reg;
    assign hit         = cmd.shift && (fill_next == FW'(kfc_pkg::KMER_LENGTH))
                         && (64'(window_next >> TB) == 64'(pass_sel_reg));
    assign rd_addr     = cmd.issue_read ? s_data.read_index[TB-1:0] : window_next[TB-1:0];

    // bypass the write that landed in the same cycle as this read
    assign s2_val = (wr_valid_reg && (wr_addr_reg == s2_addr_reg)) ? wr_data_reg : mem_q_reg;
    assign s2_inc = (s2_val == kfc_pkg::COUNT_MAX) ? s2_val : s2_val + 1'b1;

    assign stat.read_ok  = !s2_rd_reg && (!m_valid_reg || m_ready);
    assign stat.clr_last = (clr_addr_reg == '1);

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (cmd.clr_write) begin
            mem[clr_addr_reg] <= '0;
        end else if (s2_cnt_reg) begin
            mem[s2_addr_reg] <= s2_inc;
        end
        mem_q_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg   <= '0;
            fill_reg     <= '0;
            pass_sel_reg <= '0;
            clr_addr_reg <= '0;
            s2_cnt_reg   <= 1'b0;
            s2_rd_reg    <= 1'b0;
            wr_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                pass_sel_reg <= cfg_data;
            end
            if (cmd.clr_window) begin
                window_reg <= '0;
                fill_reg   <= '0;
            end else if (cmd.shift) begin
                window_reg <= window_next;
                fill_reg   <= fill_next;
            end
            if (cmd.clr_start) begin
                clr_addr_reg <= '0;
            end else if (cmd.clr_write) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            s2_cnt_reg   <= hit;
            s2_rd_reg    <= cmd.issue_read;
            wr_valid_reg <= s2_cnt_reg;
            if (s2_rd_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_byte) begin
            byte_reg <= s_data.data_byte;
        end
        s2_addr_reg <= rd_addr;
        wr_addr_reg <= s2_addr_reg;
        wr_data_reg <= s2_inc;
        if (s2_rd_reg) begin
            m_data_reg.count       <= 32'(s2_val);
            m_data_reg.count_index <= 16'(s2_addr_reg);
        end
    end

endmodule

// ----- hw/rtl/kmer_frequency_counter.sv -----
// channel   direction  handshake              word
// s_        in         s_valid / s_ready      in_word_t  {mode, data_byte, read_index}
// m_        out        m_valid / m_ready      out_word_t {count, count_index}
// cfg_      in         cfg_valid / cfg_ready  pass_select, 16 bits
//
// Feed word: four bases, one base per cycle through the counter memory's
//   read-modify-write path (the write of the last base overlaps the next word).
// Read word: the count passes the memory read register and then the result register to m_.
// Clear word and reset: a clearing pass over 2^TABLE_BITS entries (65536), one
//   entry per cycle, during which s_ready is low; cfg_ is always ready.
// A read word is held off in the cycle right after another read word and
//   while an earlier result still waits on m_.
module kmer_frequency_counter (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  kfc_pkg::in_word_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output kfc_pkg::out_word_t  m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data
);

    kfc_pkg::ctrl_cmd_t  cmd;
    kfc_pkg::dp_status_t stat;

    assign cfg_ready = 1'b1;

    kfc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_mode  (s_data.mode),
        .stat    (stat),
        .cmd     (cmd)
    );

    kfc_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

    a_no_accept_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clr_write |-> !s_ready)
        else $error("word accepted during clearing pass");

    a_read_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_data.mode == kfc_pkg::MODE_READ)) |-> ##2 m_valid)
        else $error("read word gave no result");

    a_no_shift_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.shift && cmd.clr_write))
        else $error("base shifted during clearing pass");

endmodule

// ----- sim/kmer_frequency_counter_tb.sv -----
module kmer_frequency_counter_tb;

    localparam int          SETTLE_CYCLES = 8;
    localparam int          CYCLE_LIMIT   = 2_000_000;
    localparam logic [1:0]  MODE_SPARE    = 2'd3;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    kfc_pkg::in_word_t   s_data;
    logic                m_valid;
    logic                m_ready;
    kfc_pkg::out_word_t  m_data;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [15:0]         cfg_data;

    // mirror of the counter state
    logic [31:0] win_bases;
    int          bases_held;
    logic [15:0] part_sel;
    bit   [31:0] tally [bit [15:0]];

    kfc_pkg::out_word_t pending_counts[$];
    int          mismatches = 0;
    int          cycles = 0;
    bit          calm = 1'b0;

    kmer_frequency_counter i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("kmer_frequency_counter verification failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic kfc_pkg::in_word_t feed_word(logic [7:0] b);
        kfc_pkg::in_word_t w;
        w.mode       = kfc_pkg::MODE_FEED;
        w.data_byte  = b;
        w.read_index = 16'($urandom);
        return w;
    endfunction

    function automatic kfc_pkg::in_word_t read_word(logic [15:0] idx);
        kfc_pkg::in_word_t w;
        w.mode       = kfc_pkg::MODE_READ;
        w.data_byte  = 8'($urandom);
        w.read_index = idx;
        return w;
    endfunction

    function automatic kfc_pkg::in_word_t other_word(logic [1:0] mode);
        kfc_pkg::in_word_t w;
        w            = kfc_pkg::in_word_t'($urandom);
        w.mode       = mode;
        return w;
    endfunction

    function automatic logic [31:0] tally_at(logic [15:0] idx);
        return tally.exists(idx) ? tally[idx] : 32'd0;
    endfunction

    task automatic count_word(input kfc_pkg::in_word_t w);
        kfc_pkg::out_word_t want;
        logic [1:0]  base;
        logic [31:0] cur;
        case (w.mode)
            kfc_pkg::MODE_FEED: begin
                for (int b = 0; b < 4; b++) begin
                    base      = w.data_byte[7 - 2*b -: 2];
                    win_bases = {win_bases[29:0], base};
                    if (bases_held < kfc_pkg::KMER_LENGTH)
                        bases_held++;
                    if (bases_held == kfc_pkg::KMER_LENGTH && win_bases[31:16] == part_sel) begin
                        cur = tally_at(win_bases[15:0]);
                        if (cur != kfc_pkg::COUNT_MAX)
                            tally[win_bases[15:0]] = cur + 32'd1;
                    end
                end
            end
            kfc_pkg::MODE_READ: begin
                want.count       = tally_at(w.read_index);
                want.count_index = w.read_index;
                pending_counts.push_back(want);
            end
            kfc_pkg::MODE_CLEAR: begin
                tally.delete();
                win_bases  = '0;
                bases_held = 0;
            end
            default: ;
        endcase
    endtask

    task automatic send_word(input kfc_pkg::in_word_t w);
        int idle;
        idle = pick_gap();
        @(negedge aclk);
        if (idle > 0) begin
            s_valid <= 1'b0;
            repeat (idle) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        count_word(w);
    endtask

    // block must be quiet: no word pending, results drained, clearing pass done
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_counts.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    task automatic write_pass_select(input logic [15:0] v);
        settle();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        part_sel = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
        cfg_data  <= 16'($urandom);
    endtask

    // result side: random back-pressure
    initial begin
        int stall;
        stall   = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall > 0)
                stall--;
            else if ($urandom_range(0, 3) == 0)
                stall = pick_gap();
            m_ready <= (stall == 0);
        end
    end

    always @(posedge aclk) begin
        kfc_pkg::out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_counts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected count word %h/%h", m_data.count, m_data.count_index);
            end else begin
                want = pending_counts.pop_front();
                if (m_data.count !== want.count || m_data.count_index !== want.count_index) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("count mismatch: expected %h/%h got %h/%h", want.count,
                                 want.count_index, m_data.count, m_data.count_index);
                end
            end
        end
    end

    task automatic test_reset_state();
        send_word(read_word(16'h0000));
        send_word(read_word(16'hFFFF));
    endtask

    task automatic test_partial_window();
        write_pass_select(16'h0000);
        repeat (3) send_word(feed_word(8'h00));
        send_word(read_word(16'h0000));
        send_word(feed_word(8'h00));
        send_word(read_word(16'h0000));
    endtask

    task automatic test_spare_mode();
        send_word(other_word(MODE_SPARE));
        send_word(read_word(16'h0000));
        send_word(feed_word(8'h00));
        send_word(read_word(16'h0000));
    endtask

    task automatic test_top_partition();
        write_pass_select(16'hFFFF);
        repeat (4) send_word(feed_word(8'hFF));
        send_word(read_word(16'hFFFF));
        send_word(read_word(16'h0000));
        send_word(feed_word(8'h1B));
        send_word(read_word(16'hFFFF));
    endtask

    task automatic test_clear();
        send_word(other_word(kfc_pkg::MODE_CLEAR));
        send_word(read_word(16'hFFFF));
        send_word(read_word(16'h0000));
        repeat (4) send_word(feed_word(8'hFF));
        send_word(read_word(16'hFFFF));
    endtask

    // mostly aligned 16-base groups that hit the selected partition
    task automatic test_random_streams();
        logic [15:0] hot [6];
        logic [15:0] idx;
        int          sent;
        int          r;
        for (int phase = 0; phase < 6; phase++) begin
            calm = (phase == 2);
            case (phase)
                0:       write_pass_select(16'h0000);
                1:       write_pass_select(16'hFFFF);
                default: write_pass_select(16'($urandom));
            endcase
            foreach (hot[k])
                hot[k] = 16'($urandom);
            sent = 0;
            while (sent < 280) begin
                if ($urandom_range(0, 59) == 0)
                    calm = ~calm;
                r = $urandom_range(0, 99);
                if (phase % 2 == 1 && sent >= 140 && sent < 144) begin
                    send_word(other_word(kfc_pkg::MODE_CLEAR));
                    sent += 4;
                end else if (r < 55) begin
                    idx = hot[$urandom_range(0, 5)];
                    send_word(feed_word(part_sel[15:8]));
                    send_word(feed_word(part_sel[7:0]));
                    send_word(feed_word(idx[15:8]));
                    send_word(feed_word(idx[7:0]));
                    sent += 4;
                end else if (r < 75) begin
                    send_word(read_word(hot[$urandom_range(0, 5)]));
                    sent++;
                end else if (r < 83) begin
                    send_word(read_word(16'($urandom)));
                    sent++;
                end else if (r < 97) begin
                    send_word(feed_word(8'($urandom)));
                    sent++;
                end else begin
                    send_word(other_word(MODE_SPARE));
                end
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        win_bases  = '0;
        bases_held = 0;
        part_sel   = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        settle();

        test_reset_state();
        test_partial_window();
        test_spare_mode();
        test_top_partition();
        test_clear();
        test_random_streams();

        settle();
        repeat (4 * SETTLE_CYCLES) @(posedge aclk);
        if (pending_counts.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("kmer_frequency_counter verification clean");
        else
            $display("kmer_frequency_counter verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/kfc_pkg.sv
hw/rtl/kfc_ctrl.sv
hw/rtl/kfc_datapath.sv
hw/rtl/kmer_frequency_counter.sv
sim/kmer_frequency_counter_tb.sv
